// ===== rtl/ths_pkg.sv =====
package ths_pkg;

	localparam int HASH_SLOTS_DEF = 1024;
	localparam int MAX_TUPLES_DEF = 768;
	localparam int MAX_ARITY_DEF  = 8;
	localparam int COL_W          = 32;
	localparam int CMD_W          = 2;
	localparam int STATUS_W       = 2;
	localparam int FIELD_W        = 10;
	localparam int ARITY_W        = 4;
	localparam int HASH_W         = 64;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [HASH_W-1:0] FNV_MULT  = 64'h00000100000001B3;
	localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_TEST  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_COL_RD,
		S_COL_CHK,
		S_WRITE,
		S_SLOT_WR,
		S_DONE
	} state_t;

endpackage

// ===== rtl/ths_if.sv =====
interface ths_in_if
	import ths_pkg::*;
;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [COL_W-1:0] col0;
	logic [COL_W-1:0] col1;
	logic [COL_W-1:0] col2;
	logic [COL_W-1:0] col3;
	logic [COL_W-1:0] col4;
	logic [COL_W-1:0] col5;
	logic [COL_W-1:0] col6;
	logic [COL_W-1:0] col7;

	modport source (output valid, command, col0, col1, col2, col3, col4, col5, col6, col7,
		input ready);
	modport sink (input valid, command, col0, col1, col2, col3, col4, col5, col6, col7,
		output ready);
endinterface

interface ths_out_if
	import ths_pkg::*;
;
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0] entry_index;
	logic [FIELD_W-1:0] tuple_count;

	modport source (output valid, status, entry_index, tuple_count, input ready);
	modport sink (input valid, status, entry_index, tuple_count, output ready);
endinterface

// ===== rtl/tuple_hash_set_dedup_top.sv =====
// Tuple set with deduplication. Commands arrive as beats on the input channel
// (command plus eight 32-bit columns); each command yields exactly one result
// beat on the output channel (status, entry_index, tuple_count). The arity
// register is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. A command
// is taken only when the block is idle and the output register is empty, so
// one command is in flight at a time. The key is hashed one byte per cycle over
// the active columns. Each probe of the slot table then reads and checks a slot,
// and each compared column is read from the tuple store and compared. An add
// of a new tuple writes all eight store columns, one per cycle, then the slot,
// unless the store or the slot table is full.
// Reset clears control state and starts a pass that clears the slot table,
// one slot per cycle (HASH_SLOTS slots, 1024 by default); no command is taken
// during it and it yields no result beat. A clear command runs the same pass,
// sets the tuple count to zero and then answers. When the receiver stalls
// the result waits in the output register and no new command is taken.
module tuple_hash_set_dedup_top
	import ths_pkg::*;
#(
	parameter int HASH_SLOTS = HASH_SLOTS_DEF,
	parameter int MAX_TUPLES = MAX_TUPLES_DEF,
	parameter int MAX_ARITY  = MAX_ARITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ARITY_W-1:0] cfg_wdata,
	ths_in_if.sink             in_ch,
	ths_out_if.source          out_ch
);

	localparam int SLOT_AW = $clog2(HASH_SLOTS);
	localparam int ROW_AW  = $clog2(MAX_TUPLES);
	localparam int COL_AW  = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;
	localparam int STORE_D = MAX_TUPLES * MAX_ARITY;
	localparam int STORE_AW = $clog2(STORE_D);
	localparam int SLOT_DW = FIELD_W;

	// Slot table and tuple store, both with registered reads.
	logic [SLOT_DW-1:0] slot_mem [HASH_SLOTS];
	logic [COL_W-1:0]   store_mem [STORE_D];

	state_t state_q, state_d;
	logic [ARITY_W-1:0]    arity_q;
	logic [3:0]            n_q;           // active column count, 1..MAX_ARITY
	logic [CMD_W-1:0]      cmd_q;
	logic [COL_W-1:0]      cols_q [MAX_ARITY];
	logic [HASH_W-1:0]     hash_q;
	logic [5:0]            byte_q;        // byte counter over the hash
	logic [SLOT_AW-1:0]    idx_q;
	logic [SLOT_AW:0]      probes_q;
	logic [SLOT_DW-1:0]    slot_rd_q;
	logic [SLOT_DW-1:0]    cand_q;
	logic [COL_AW:0]       col_q;
	logic [COL_W-1:0]      store_rd_q;
	logic [FIELD_W-1:0]    count_q;
	logic                  free_ok_q;
	logic [SLOT_AW-1:0]    free_q;
	logic [SLOT_AW:0]      clr_q;
	logic                  boot_q;        // set while the reset clearing pass runs
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [FIELD_W-1:0]    index_q;

	logic [3:0] n_eff;
	logic [COL_W-1:0] in_cols [8];
	logic [7:0] hash_byte;
	logic [COL_AW-1:0] hcol;
	logic accept;
	logic [HASH_W-1:0] hash_mix;
	logic [HASH_W-1:0] hash_next;

	assign in_cols[0] = in_ch.col0;
	assign in_cols[1] = in_ch.col1;
	assign in_cols[2] = in_ch.col2;
	assign in_cols[3] = in_ch.col3;
	assign in_cols[4] = in_ch.col4;
	assign in_cols[5] = in_ch.col5;
	assign in_cols[6] = in_ch.col6;
	assign in_cols[7] = in_ch.col7;

	always_comb begin
		if (arity_q == '0)
			n_eff = 4'd1;
		else if (arity_q > ARITY_W'(MAX_ARITY))
			n_eff = 4'(MAX_ARITY);
		else
			n_eff = arity_q;
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = in_ch.valid && in_ch.ready;

	assign hcol = byte_q[COL_AW+1:2];
	assign hash_byte = 8'(cols_q[hcol] >> {byte_q[1:0], 3'b000});
	assign hash_mix = hash_q ^ {56'd0, hash_byte};
	// The FNV prime is 2^40 + 0x1B3, so the multiply is a sum of shifted copies.
	assign hash_next = (hash_mix << 40) + (hash_mix << 8) + (hash_mix << 7) +
		(hash_mix << 5) + (hash_mix << 4) + (hash_mix << 1) + hash_mix;

	logic row_ok;
	logic [STORE_AW-1:0] rd_addr;
	logic [STORE_AW-1:0] wr_addr;
	logic [ROW_AW-1:0]   cand_row;
	logic [ROW_AW-1:0]   wr_row;
	assign row_ok   = (slot_rd_q != '0) && (FIELD_W'(slot_rd_q - 1'b1) < FIELD_W'(MAX_TUPLES));
	assign cand_row = ROW_AW'(cand_q - 1'b1);
	assign wr_row   = ROW_AW'(count_q);
	assign rd_addr  = STORE_AW'(cand_row * MAX_ARITY) + STORE_AW'(col_q[COL_AW-1:0]);
	assign wr_addr  = STORE_AW'(wr_row * MAX_ARITY) + STORE_AW'(col_q[COL_AW-1:0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_ch.command == CMD_CLEAR)
						state_d = S_CLEAR;
					else if (in_ch.command != CMD_ADD && count_q == '0)
						state_d = S_DONE;
					else
						state_d = S_HASH;
				end
			end
			S_CLEAR: begin
				if (clr_q == (SLOT_AW+1)'(HASH_SLOTS - 1))
					state_d = boot_q ? S_IDLE : S_DONE;
			end
			S_HASH: begin
				if (byte_q == 6'({n_q, 2'b00} - 1'b1))
					state_d = S_SLOT_RD;
			end
			S_SLOT_RD:  state_d = S_SLOT_CHK;
			S_SLOT_CHK: begin
				if (slot_rd_q == '0)
					state_d = (cmd_q == CMD_ADD) ? S_WRITE : S_DONE;
				else if (row_ok)
					state_d = S_COL_RD;
				else if (probes_q == (SLOT_AW+1)'(HASH_SLOTS - 1))
					state_d = (cmd_q == CMD_ADD) ? S_WRITE : S_DONE;
				else
					state_d = S_SLOT_RD;
			end
			S_COL_RD:  state_d = S_COL_CHK;
			S_COL_CHK: begin
				if (store_rd_q != cols_q[col_q[COL_AW-1:0]]) begin
					if (probes_q == (SLOT_AW+1)'(HASH_SLOTS - 1))
						state_d = (cmd_q == CMD_ADD) ? S_WRITE : S_DONE;
					else
						state_d = S_SLOT_RD;
				end else if (col_q == (COL_AW+1)'(n_q - 1'b1))
					state_d = S_DONE;
				else
					state_d = S_COL_RD;
			end
			S_WRITE: begin
				if (count_q >= FIELD_W'(MAX_TUPLES) || !free_ok_q)
					state_d = S_DONE;
				else if (col_q == (COL_AW+1)'(MAX_ARITY - 1))
					state_d = S_SLOT_WR;
			end
			S_SLOT_WR: state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			arity_q     <= ARITY_RESET;
			count_q     <= '0;
			clr_q       <= '0;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				arity_q <= cfg_wdata;
			if (state_q != S_CLEAR)
				boot_q <= 1'b0;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
			else
				clr_q <= '0;
			if (accept && in_ch.command == CMD_CLEAR)
				count_q <= '0;
			else if (state_q == S_SLOT_WR)
				count_q <= count_q + 1'b1;
			if (state_q == S_DONE)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers; results are settled in S_DONE from these.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_ch.command;
			n_q      <= n_eff;
			hash_q   <= FNV_BASIS;
			byte_q   <= '0;
			probes_q <= '0;
			free_ok_q <= 1'b0;
			col_q    <= '0;
			status_q <= (in_ch.command == CMD_ADD || in_ch.command == CMD_CLEAR) ?
				ST_OK : ST_ABSENT;
			index_q  <= '0;
			for (int i = 0; i < MAX_ARITY; i++)
				cols_q[i] <= (4'(i) < n_eff) ? in_cols[i] : '0;
		end
		case (state_q)
			S_HASH: begin
				hash_q <= hash_next;
				byte_q <= byte_q + 1'b1;
				if (byte_q == 6'({n_q, 2'b00} - 1'b1))
					idx_q <= hash_next[SLOT_AW-1:0];
			end
			S_SLOT_RD: begin
				slot_rd_q <= slot_mem[idx_q];
				col_q <= '0;
			end
			S_SLOT_CHK: begin
				cand_q <= slot_rd_q;
				if (slot_rd_q == '0) begin
					free_ok_q <= 1'b1;
					free_q    <= idx_q;
					col_q     <= '0;
				end else if (!row_ok) begin
					idx_q    <= idx_q + 1'b1;
					probes_q <= probes_q + 1'b1;
				end
			end
			S_COL_RD: store_rd_q <= store_mem[rd_addr];
			S_COL_CHK: begin
				if (store_rd_q != cols_q[col_q[COL_AW-1:0]]) begin
					idx_q    <= idx_q + 1'b1;
					probes_q <= probes_q + 1'b1;
					col_q    <= '0;
				end else if (col_q == (COL_AW+1)'(n_q - 1'b1)) begin
					status_q <= ST_PRESENT;
					index_q  <= cand_q;
				end else
					col_q <= col_q + 1'b1;
			end
			S_WRITE: begin
				if (count_q >= FIELD_W'(MAX_TUPLES) || !free_ok_q)
					status_q <= ST_FULL;
				else begin
					store_mem[wr_addr] <= cols_q[col_q[COL_AW-1:0]];
					col_q <= col_q + 1'b1;
				end
			end
			S_SLOT_WR: begin
				slot_mem[free_q] <= count_q + 1'b1;
				index_q <= count_q + 1'b1;
			end
			S_CLEAR: slot_mem[clr_q[SLOT_AW-1:0]] <= '0;
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.entry_index = index_q;
	assign out_ch.tuple_count = count_q;

endmodule

// ===== dv/tuple_hash_set_dedup_top_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the tuple set. It keeps its own copy of the slot table, the tuple
// store and the count, and predicts the result of every command beat. A driver
// feeds command beats from a queue that an initial block fills. A monitor checks
// every result beat against the oldest prediction.
module tuple_hash_set_dedup_top_tb;
	import ths_pkg::*;

	localparam int NSLOT = HASH_SLOTS_DEF;
	localparam int NROW = MAX_TUPLES_DEF;
	localparam int NCOL = MAX_ARITY_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		cmd_t cmd;
		logic [NCOL-1:0][COL_W-1:0] cols;
	} set_cmd_t;

	typedef struct packed {
		status_t status;
		logic [FIELD_W-1:0] entry_index;
		logic [FIELD_W-1:0] tuple_count;
	} set_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ARITY_W-1:0] cfg_wdata = '0;

	ths_in_if in_ch ();
	ths_out_if out_ch ();

	tuple_hash_set_dedup_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the block's state.
	logic [ARITY_W-1:0] arity_reg;
	logic [FIELD_W-1:0] slot_shadow [NSLOT];
	logic [COL_W-1:0] row_shadow [NROW][NCOL];
	int unsigned held;

	set_cmd_t cmd_queue[$];
	set_resp_t resp_queue[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int unsigned idle_cycles = 0;
	int unsigned in_beats = 0;
	int unsigned in_seen = 0;
	bit mismatch = 0;

	// Tuples added so far in this phase, kept so that random adds and tests
	// often hit entries that really are present.
	logic [NCOL-1:0][COL_W-1:0] known_tuples[$];

	function automatic int unsigned live_cols();
		if (arity_reg == 0)
			return 1;
		if (arity_reg > NCOL)
			return NCOL;
		return arity_reg;
	endfunction

	function automatic logic [HASH_W-1:0] fnv_over(logic [NCOL-1:0][COL_W-1:0] c,
			int unsigned n);
		logic [HASH_W-1:0] h;
		h = 64'hCBF29CE484222325;
		for (int i = 0; i < n; i++)
			for (int b = 0; b < 4; b++) begin
				h = h ^ {56'd0, c[i][8*b +: 8]};
				h = h * 64'h00000100000001B3;
			end
		return h;
	endfunction

	// Walks the probe chain. Returns the row found (1-based) or 0, and the first
	// empty slot met, or NSLOT when the table has none.
	function automatic int unsigned find_row(logic [NCOL-1:0][COL_W-1:0] c,
			int unsigned n, output int unsigned free_slot);
		int unsigned pos;
		int unsigned s;
		bit same;
		pos = fnv_over(c, n) % NSLOT;
		free_slot = NSLOT;
		for (int k = 0; k < NSLOT; k++) begin
			s = slot_shadow[pos];
			if (s == 0) begin
				free_slot = pos;
				return 0;
			end
			if (s <= NROW) begin
				same = 1;
				for (int i = 0; i < n; i++)
					if (row_shadow[s-1][i] != c[i])
						same = 0;
				if (same)
					return s;
			end
			pos = (pos + 1) % NSLOT;
		end
		return 0;
	endfunction

	function automatic set_resp_t apply_command(set_cmd_t item);
		set_resp_t r;
		logic [NCOL-1:0][COL_W-1:0] c;
		int unsigned n;
		int unsigned hit;
		int unsigned free_slot;
		n = live_cols();
		c = '0;
		for (int i = 0; i < n; i++)
			c[i] = item.cols[i];
		r.status = ST_OK;
		r.entry_index = '0;
		if (item.cmd == CMD_CLEAR) begin
			foreach (slot_shadow[i])
				slot_shadow[i] = '0;
			held = 0;
		end else if (item.cmd == CMD_ADD) begin
			hit = find_row(c, n, free_slot);
			if (hit != 0) begin
				r.status = ST_PRESENT;
				r.entry_index = FIELD_W'(hit);
			end else if (held >= NROW || free_slot >= NSLOT) begin
				r.status = ST_FULL;
			end else begin
				for (int i = 0; i < NCOL; i++)
					row_shadow[held][i] = c[i];
				held++;
				slot_shadow[free_slot] = FIELD_W'(held);
				r.entry_index = FIELD_W'(held);
			end
		end else begin
			hit = (held == 0) ? 0 : find_row(c, n, free_slot);
			if (hit != 0) begin
				r.status = ST_PRESENT;
				r.entry_index = FIELD_W'(hit);
			end else begin
				r.status = ST_ABSENT;
			end
		end
		r.tuple_count = FIELD_W'(held);
		return r;
	endfunction

	// Driver: presents the next queued command. A beat that is still waiting
	// (not yet counted as taken by the monitor) is held unchanged.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_ch.valid && in_seen == in_beats)) begin
				in_seen = in_beats;
				if (cmd_queue.size() > 0 && $urandom_range(99) < send_idle_pct) begin
					in_ch.valid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.command <= cmd_queue[0].cmd;
					in_ch.col0 <= cmd_queue[0].cols[0];
					in_ch.col1 <= cmd_queue[0].cols[1];
					in_ch.col2 <= cmd_queue[0].cols[2];
					in_ch.col3 <= cmd_queue[0].cols[3];
					in_ch.col4 <= cmd_queue[0].cols[4];
					in_ch.col5 <= cmd_queue[0].cols[5];
					in_ch.col6 <= cmd_queue[0].cols[6];
					in_ch.col7 <= cmd_queue[0].cols[7];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts each taken command, checks each result beat and counts
	// cycles in which no beat moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				resp_queue.push_back(apply_command(cmd_queue.pop_front()));
				in_beats <= in_beats + 1;
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (resp_queue.size() == 0) begin
					$display("%0t: unexpected result status=%0d index=%0d count=%0d",
						$time, out_ch.status, out_ch.entry_index, out_ch.tuple_count);
					mismatch = 1;
				end else begin
					set_resp_t want;
					// A result never leaves in the cycle its command is taken.
					want = resp_queue.pop_front();
					if (out_ch.status != want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, out_ch.status);
						mismatch = 1;
					end
					if (out_ch.entry_index != want.entry_index) begin
						$display("%0t: entry_index expected %0d actual %0d", $time,
							want.entry_index, out_ch.entry_index);
						mismatch = 1;
					end
					if (out_ch.tuple_count != want.tuple_count) begin
						$display("%0t: tuple_count expected %0d actual %0d", $time,
							want.tuple_count, out_ch.tuple_count);
						mismatch = 1;
					end
				end
			end
			if (idle_cycles > STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic [COL_W-1:0] rand_col();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [NCOL-1:0][COL_W-1:0] rand_tuple();
		logic [NCOL-1:0][COL_W-1:0] t;
		for (int i = 0; i < NCOL; i++)
			t[i] = rand_col();
		return t;
	endfunction

	task automatic queue_cmd(cmd_t cmd, logic [NCOL-1:0][COL_W-1:0] cols);
		set_cmd_t item;
		item.cmd = cmd;
		item.cols = cols;
		cmd_queue.push_back(item);
		if (cmd == CMD_CLEAR)
			known_tuples.delete();
		else if (cmd == CMD_ADD)
			known_tuples.push_back(cols);
	endtask

	// Waits until every queued command has been taken and answered, plus a
	// margin for a clear pass still running inside the block.
	task automatic drain();
		wait (cmd_queue.size() == 0 && !in_ch.valid);
		wait (resp_queue.size() == 0);
		repeat (NSLOT + 100) @(posedge clk);
	endtask

	task automatic set_arity(logic [ARITY_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		arity_reg = value;
	endtask

	// A random phase: mostly adds and tests, of tuples already added or of fresh
	// tuples, a few unused commands and rare clears.
	task automatic random_phase(int count);
		logic [NCOL-1:0][COL_W-1:0] t;
		int pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (known_tuples.size() > 0 && pick < 45)
				t = known_tuples[$urandom_range(known_tuples.size() - 1)];
			else
				t = rand_tuple();
			// Flip one bit now and then to get near misses.
			if (pick >= 30 && pick < 40)
				t[$urandom_range(NCOL-1)][$urandom_range(COL_W-1)] ^= 1'b1;
			pick = $urandom_range(99);
			if (pick < 50)
				queue_cmd(CMD_ADD, t);
			else if (pick < 94)
				queue_cmd(CMD_TEST, t);
			else if (pick < 99)
				queue_cmd(CMD_NONE, t);
			else
				queue_cmd(CMD_CLEAR, t);
		end
		wait (cmd_queue.size() == 0);
	endtask

	initial begin
		logic [NCOL-1:0][COL_W-1:0] t;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TEST;
		{in_ch.col0, in_ch.col1, in_ch.col2, in_ch.col3} = '0;
		{in_ch.col4, in_ch.col5, in_ch.col6, in_ch.col7} = '0;
		out_ch.ready = 1'b0;
		arity_reg = ARITY_RESET;
		held = 0;
		foreach (slot_shadow[i])
			slot_shadow[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 66;

		// Directed part at the reset arity: test on an empty set, extreme
		// columns, duplicates, the unused command and a clear.
		queue_cmd(CMD_TEST, '0);
		queue_cmd(CMD_ADD, '0);
		queue_cmd(CMD_ADD, '1);
		queue_cmd(CMD_ADD, '0);
		queue_cmd(CMD_TEST, '1);
		t = '1;
		t[1] = 32'hFFFFFFFE;
		queue_cmd(CMD_TEST, t);
		queue_cmd(CMD_NONE, '1);
		// Columns beyond the arity do not take part.
		t = '0;
		t[5] = 32'hDEADBEEF;
		queue_cmd(CMD_ADD, t);
		queue_cmd(CMD_CLEAR, '1);
		queue_cmd(CMD_TEST, '0);
		drain();

		// Arity changed without a clear keeps the rows; compares use the new
		// arity against rows whose high columns were stored as zero.
		set_arity(4'd8);
		queue_cmd(CMD_TEST, '0);
		queue_cmd(CMD_ADD, '1);
		queue_cmd(CMD_TEST, '1);
		drain();
		set_arity(4'd0);
		queue_cmd(CMD_TEST, '0);
		queue_cmd(CMD_ADD, {{7{32'h5}}, 32'h80000000});
		drain();
		set_arity(4'd15);
		queue_cmd(CMD_TEST, '1);
		queue_cmd(CMD_CLEAR, '0);
		drain();

		// Fill the store to its limit at arity 1, then try more adds and a
		// duplicate while full.
		set_arity(4'd1);
		recv_idle_pct = 0;
		send_idle_pct = 0;
		for (int i = 0; i < NROW + 3; i++) begin
			t = '0;
			t[0] = i * 32'h9E3779B1;
			queue_cmd(CMD_ADD, t);
		end
		queue_cmd(CMD_ADD, '0);
		queue_cmd(CMD_TEST, t);
		queue_cmd(CMD_CLEAR, '0);
		drain();

		// Random phases over several arities and three idling patterns.
		send_idle_pct = 18;
		recv_idle_pct = 66;
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 66;
				recv_idle_pct = 18;
			end else if (ph == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			set_arity(ARITY_W'($urandom_range(15)));
			queue_cmd(CMD_CLEAR, '0);
			random_phase(65);
		end

		drain();
		if (!mismatch) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
